@@ hdl/zcd_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the ZipCrypto decryptor.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package zcd_pkg;

    typedef enum logic [1:0] {
        REQ_RESTART  = 2'd0,
        REQ_PASSWORD = 2'd1,
        REQ_DECRYPT  = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_t;

    typedef enum logic {
        ST_IDLE,
        ST_MIX
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_init;  // load the fixed initial keys
        logic step1;      // crc_key update and lcg pre-sum
        logic use_plain;  // mix the decrypted byte instead of the raw input byte
        logic step2;      // lcg multiply and stream_key update
        logic out_load;   // move the pending plain byte into the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;   // output register holds a beat that is stalled
    } dp_stat_t;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] LCG_MULT    = 32'd134775813;
    localparam logic [31:0] INIT_CRC    = 32'h1234_5678;
    localparam logic [31:0] INIT_LCG    = 32'h2345_6789;
    localparam logic [31:0] INIT_STREAM = 32'h3456_7890;

    // One reflected CRC-32 byte step; the bit loop folds into a fixed XOR network.
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] t;
        t = {24'd0, crc[7:0] ^ b};
        for (int i = 0; i < 8; i++)
        begin
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        end
        return {8'd0, crc[31:8]} ^ t;
    endfunction

endpackage

`default_nettype wire

@@ hdl/zcd_ctrl.sv @@
// Controller state machine for the ZipCrypto decryptor.
// Depends on zcd_pkg; drives the datapath in zcd_dpath through dp_cmd_t.
`default_nettype none

module zcd_ctrl
    import zcd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire logic [1:0] req_type,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   dec_reg, dec_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dec_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dec_reg   <= dec_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dec_next   = dec_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (req_t'(req_type))
                        REQ_RESTART:
                        begin
                            cmd.load_init = 1'b1;
                        end
                        REQ_PASSWORD:
                        begin
                            cmd.step1  = 1'b1;
                            dec_next   = 1'b0;
                            state_next = ST_MIX;
                        end
                        REQ_DECRYPT:
                        begin
                            cmd.step1     = 1'b1;
                            cmd.use_plain = 1'b1;
                            dec_next      = 1'b1;
                            state_next    = ST_MIX;
                        end
                        default:
                        begin
                            // unused code: drop the beat
                        end
                    endcase
                end
            end
            ST_MIX:
            begin
                // hold while a decrypt result has nowhere to go
                if (!(dec_reg && stat.out_busy))
                begin
                    cmd.step2    = 1'b1;
                    cmd.out_load = dec_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/zcd_dpath.sv @@
// Key registers, keystream multiply, CRC steps and output register.
// Depends on zcd_pkg; commanded by zcd_ctrl.
`default_nettype none

module zcd_dpath
    import zcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dp_cmd_t    cmd,
    output dp_stat_t        stat,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      plain_byte
);

    logic [31:0] crc_key_reg, crc_key_next;
    logic [31:0] lcg_key_reg, lcg_key_next;
    logic [31:0] stream_key_reg, stream_key_next;
    logic [31:0] sum_reg, sum_next;
    logic [7:0]  pend_reg, pend_next;
    logic [7:0]  plain_reg, plain_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] ks_t;
    logic [31:0] ks_prod;
    logic [7:0]  plain_now;
    logic [7:0]  mix_byte;
    logic [31:0] crc_upd;
    logic [31:0] lcg_upd;

    // Keystream byte from stream_key, then the crc_key step and the lcg pre-sum
    assign ks_t      = stream_key_reg | 32'd2;
    assign ks_prod   = ks_t * (ks_t ^ 32'd1);
    assign plain_now = data_byte ^ ks_prod[15:8];
    assign mix_byte  = cmd.use_plain ? plain_now : data_byte;
    assign crc_upd   = crc_step(crc_key_reg, mix_byte);

    // Second half: lcg multiply, then the stream_key step on its top byte
    assign lcg_upd   = sum_reg * LCG_MULT + 32'd1;

    always_comb
    begin
        crc_key_next    = crc_key_reg;
        lcg_key_next    = lcg_key_reg;
        stream_key_next = stream_key_reg;
        sum_next        = sum_reg;
        pend_next       = pend_reg;
        plain_next      = plain_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (cmd.load_init)
        begin
            crc_key_next    = INIT_CRC;
            lcg_key_next    = INIT_LCG;
            stream_key_next = INIT_STREAM;
        end
        if (cmd.step1)
        begin
            crc_key_next = crc_upd;
            sum_next     = lcg_key_reg + {24'd0, crc_upd[7:0]};
            pend_next    = plain_now;
        end
        if (cmd.step2)
        begin
            lcg_key_next    = lcg_upd;
            stream_key_next = crc_step(stream_key_reg, lcg_upd[31:24]);
        end
        if (cmd.out_load)
        begin
            plain_next     = pend_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_key_reg    <= INIT_CRC;
            lcg_key_reg    <= INIT_LCG;
            stream_key_reg <= INIT_STREAM;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            crc_key_reg    <= crc_key_next;
            lcg_key_reg    <= lcg_key_next;
            stream_key_reg <= stream_key_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        pend_reg  <= pend_next;
        plain_reg <= plain_next;
    end

    assign stat.out_busy = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign plain_byte    = plain_reg;

endmodule

`default_nettype wire

@@ hdl/zip_traditional_decrypt.sv @@
// Top level of the traditional PKZIP (ZipCrypto) stream decryptor.
// Depends on zcd_pkg, zcd_ctrl and zcd_dpath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | to block  | in_valid / in_stall  | req_type[1:0], data_byte[7:0]
//  out     | from block| out_valid / out_stall| plain_byte[7:0]
//
// Sequencing: a password or decrypt beat is split (the accept cycle does the
//   keystream multiply and crc_key step, then state ST_MIX does the lcg multiply and
//   the stream_key step); restart and unused codes finish in the accept cycle.
// The two serial 32-bit multiplies in each key update are the reason for the split.
// Reset: rst_n (async, active low) loads the fixed initial keys and empties
//   the output register.
// Stalls: the output register lets the next beat in while a result waits;
//   a decrypt beat holds in ST_MIX only while that register is stalled.
`default_nettype none

module zip_traditional_decrypt
    import zcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      plain_byte
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: decodes the request and walks the two halves of a key update
    zcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Keys, keystream and output register
    zcd_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .plain_byte (plain_byte)
    );

`ifndef SYNTHESIS
    // An accepted password or decrypt beat always raises in_stall for its second half
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall
            && (req_type == REQ_PASSWORD || req_type == REQ_DECRYPT)) |=> in_stall)
    else $error("second half of key update skipped");

    // The two halves of the update never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step1 && cmd.step2))
    else $error("step1 and step2 issued together");

    // A result appears only after a load command from the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result beat without a decrypt");

    // A stalled result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.out_load)
    else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_zip_traditional_decrypt.sv @@
// Self-checking testbench for the ZipCrypto stream decryptor zip_traditional_decrypt.
// Needs zcd_pkg (request codes) and the RTL under hdl/; keeps its own key model.
// Directed corner beats come first, then random restart/password/decrypt runs.
`default_nettype none

module tb_zip_traditional_decrypt;
    import zcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits and the key constants used by the model
    localparam int          RAND_BEATS   = 1150;
    localparam int          IDLE_LIMIT   = 1000;
    localparam int          REPORT_MAX   = 10;
    localparam logic [31:0] POLY_REFL    = 32'hEDB8_8320;
    localparam logic [31:0] LCG_FACTOR   = 32'd134775813;
    localparam logic [31:0] SEED_CRC     = 32'd305419896;
    localparam logic [31:0] SEED_LCG     = 32'd591751049;
    localparam logic [31:0] SEED_STREAM  = 32'd878082192;

    typedef struct {
        req_t       req;
        logic [7:0] data;
        bit         drain;    // hold this beat until every pending plain byte is out
    } beat_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [1:0] req_type   = REQ_RESTART;
    logic [7:0] data_byte  = 8'd0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [7:0] plain_byte;

    zip_traditional_decrypt DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .plain_byte (plain_byte)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Key model: three 32-bit keys, advanced on every accepted password or decrypt beat
    // ------------------------------------------------------------------
    logic [31:0] crc_tab [256];
    logic [31:0] k_crc    = SEED_CRC;
    logic [31:0] k_lcg    = SEED_LCG;
    logic [31:0] k_str    = SEED_STREAM;

    beat_t       beat_q [$];      // beats waiting to be driven
    logic [7:0]  plain_q [$];     // plain bytes the block still owes us

    int err_count   = 0;
    int n_restart   = 0;
    int n_passwd    = 0;
    int n_decrypt   = 0;
    int n_unused    = 0;
    int n_checked   = 0;
    int n_drains    = 0;
    int n_live      = 0;          // generated beats the block does not ignore
    int idle_cycles = 0;
    bit took_beat   = 1'b0;

    // Table-driven reflected CRC byte step
    function automatic logic [31:0] crc_advance(input logic [31:0] c, input logic [7:0] b);
        return (c >> 8) ^ crc_tab[c[7:0] ^ b];
    endfunction

    task automatic mix_keys(input logic [7:0] b);
        k_crc = crc_advance(k_crc, b);
        k_lcg = (k_lcg + {24'd0, k_crc[7:0]}) * LCG_FACTOR + 32'd1;
        k_str = crc_advance(k_str, k_lcg[31:24]);
    endtask

    function automatic logic [7:0] keystream();
        logic [31:0] t;
        logic [31:0] p;
        t = k_str | 32'd2;
        p = t * (t ^ 32'd1);
        return p[15:8];
    endfunction

    // Apply one accepted beat to the model; queue the plain byte for decrypts
    task automatic model_beat(input req_t r, input logic [7:0] d);
        logic [7:0] pb;
        case (r)
            REQ_RESTART:
            begin
                k_crc = SEED_CRC;
                k_lcg = SEED_LCG;
                k_str = SEED_STREAM;
                n_restart++;
            end
            REQ_PASSWORD:
            begin
                mix_keys(d);
                n_passwd++;
            end
            REQ_DECRYPT:
            begin
                pb = d ^ keystream();
                mix_keys(pb);
                plain_q.push_back(pb);
                n_decrypt++;
            end
            default:
                n_unused++;
        endcase
    endtask

    task automatic queue_beat(input req_t r, input logic [7:0] d, input bit drain);
        beat_t b;
        b.req   = r;
        b.data  = d;
        b.drain = drain;
        beat_q.push_back(b);
        if (r != REQ_UNUSED)
            n_live++;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of beats with random gaps, all changes on the falling edge
    // ------------------------------------------------------------------
    int burst_left = 8;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        beat_t nb;
        bit    go;
        go = 1'b0;
        // hold the current beat until the block takes it
        if (rst_n && (!in_valid || took_beat))
        begin
            if (gap_left != 0)
                gap_left--;
            else if (beat_q.size() != 0 && !(beat_q[0].drain && plain_q.size() != 0))
                go = 1'b1;
            if (go)
            begin
                nb = beat_q.pop_front();
                if (nb.drain)
                    n_drains++;
                req_type  <= nb.req;
                data_byte <= nb.data;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    // a quarter of bursts run straight into the next one
                    if ($urandom_range(0, 3) == 0)
                        gap_left = 0;
                    else if ($urandom_range(0, 7) == 0)
                        gap_left = $urandom_range(10, 25);
                    else
                        gap_left = $urandom_range(1, 4);
                end
            end
            in_valid <= go;
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: a mode is picked for a random stretch of cycles
    //   0 never stall, 1 light random, 2 heavy random, 3 long stall runs
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 40;
    int run_left   = 0;

    always @(negedge clk)
    begin
        bit s;
        s = 1'b0;
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
            run_left   = 0;
        end
        else
            mode_left--;
        case (stall_mode)
            1: s = ($urandom_range(0, 9) < 3);
            2: s = ($urandom_range(0, 9) < 7);
            3:
            begin
                if (run_left == 0)
                    run_left = $urandom_range(1, 20);
                else
                    run_left--;
                // release at the tail of each run, once run_left drops to 3 or below
                s = (run_left > 3);
            end
            default: s = 1'b0;
        endcase
        out_stall <= s;
    end

    // ------------------------------------------------------------------
    // Monitor: check results first, then advance the model with the input beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [7:0] exp_pb;
        bit         in_hs;
        bit         out_hs;
        in_hs  = in_valid && !in_stall;
        out_hs = out_valid && !out_stall;
        if (rst_n)
        begin
            if (out_hs)
            begin
                if (plain_q.size() == 0)
                begin
                    if (err_count < REPORT_MAX)
                        $display("%0t: plain byte %02h with nothing expected", $realtime,
                                 plain_byte);
                    err_count++;
                end
                else
                begin
                    exp_pb = plain_q.pop_front();
                    n_checked++;
                    if (plain_byte !== exp_pb)
                    begin
                        if (err_count < REPORT_MAX)
                            $display("%0t: plain_byte mismatch: expected %02h, got %02h",
                                     $realtime, exp_pb, plain_byte);
                        err_count++;
                    end
                end
            end
            if (in_hs)
                model_beat(req_t'(req_type), data_byte);
            took_beat   <= in_hs;
            idle_cycles <= (in_hs || out_hs) ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: nothing moving on either channel for too long
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d plain bytes outstanding", $realtime,
                     idle_cycles, plain_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [31:0] t;
        int          plen;
        int          dlen;
        int          pick;
        int          seq_no;
        int          n_dir;

        // reflected CRC-32 byte table
        for (int i = 0; i < 256; i++)
        begin
            t = i;
            for (int j = 0; j < 8; j++)
                t = t[0] ? ((t >> 1) ^ POLY_REFL) : (t >> 1);
            crc_tab[i] = t;
        end

        // Directed: decrypt straight from the reset keys, byte extremes, unused
        // codes between decrypts, back-to-back restarts, data ignored on restart
        queue_beat(REQ_DECRYPT,  8'h00, 1'b0);
        queue_beat(REQ_DECRYPT,  8'hFF, 1'b0);
        queue_beat(REQ_UNUSED,   8'hFF, 1'b0);
        queue_beat(REQ_DECRYPT,  8'h80, 1'b0);
        queue_beat(REQ_RESTART,  8'hFF, 1'b0);
        queue_beat(REQ_PASSWORD, 8'h00, 1'b0);
        queue_beat(REQ_PASSWORD, 8'hFF, 1'b0);
        queue_beat(REQ_PASSWORD, 8'h01, 1'b0);
        queue_beat(REQ_PASSWORD, 8'h80, 1'b0);
        queue_beat(REQ_DECRYPT,  8'h01, 1'b0);
        queue_beat(REQ_UNUSED,   8'h00, 1'b0);
        queue_beat(REQ_DECRYPT,  8'h7F, 1'b0);
        queue_beat(REQ_RESTART,  8'h00, 1'b1);
        queue_beat(REQ_RESTART,  8'hA5, 1'b0);
        queue_beat(REQ_DECRYPT,  8'hAA, 1'b0);
        queue_beat(REQ_DECRYPT,  8'h55, 1'b0);
        queue_beat(REQ_PASSWORD, 8'hFE, 1'b0);
        queue_beat(REQ_DECRYPT,  8'h00, 1'b0);
        queue_beat(REQ_DECRYPT,  8'hFF, 1'b0);
        queue_beat(REQ_UNUSED,   8'h5A, 1'b0);
        queue_beat(REQ_RESTART,  8'h00, 1'b0);
        queue_beat(REQ_DECRYPT,  8'hFF, 1'b0);
        n_dir = n_live;

        // Random: mostly restart + password + encrypted header + data,
        // the rest is noise with every request code including the unused one
        seq_no = 0;
        while (n_live - n_dir < RAND_BEATS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                queue_beat(REQ_RESTART, 8'($urandom_range(0, 255)), (seq_no % 9) == 0);
                plen = $urandom_range(1, 12);
                for (int i = 0; i < plen; i++)
                    queue_beat(REQ_PASSWORD, 8'($urandom_range(0, 255)), 1'b0);
                dlen = 12 + (($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                          : $urandom_range(0, 20));
                for (int i = 0; i < dlen; i++)
                    queue_beat(REQ_DECRYPT, 8'($urandom_range(0, 255)), 1'b0);
                seq_no++;
            end
            else
            begin
                plen = $urandom_range(1, 8);
                for (int i = 0; i < plen; i++)
                    queue_beat(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               1'b0);
            end
        end

        // hold reset, then release it on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: every beat taken and every plain byte seen before the summary
        while (beat_q.size() != 0 || in_valid)
            @(posedge clk);
        while (plain_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d restarts, %0d password beats, %0d decrypt beats, %0d unused codes",
                 n_restart, n_passwd, n_decrypt, n_unused);
        $display("Checked %0d plain bytes over %0d key runs, %0d full drains under stalls",
                 n_checked, seq_no, n_drains);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/zcd_pkg.sv
hdl/zcd_ctrl.sv
hdl/zcd_dpath.sv
hdl/zip_traditional_decrypt.sv
tb/sv/tb_zip_traditional_decrypt.sv
